FILE: rtl/crc16_frame_decoder_macros.svh
// assertion helpers shared by the checker
`ifndef CRC16_FRAME_DECODER_MACROS_SVH
`define CRC16_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRC16FD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CRC16FD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crc16fd_pkg.sv
`default_nettype none

package crc16fd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // start, address, command, length, crc low, crc high
    localparam logic [9:0] FRAME_OVERHEAD = 10'd6;
    localparam logic [8:0] POS_MAX        = 9'd511;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_MIN_ADDR   = 2'd1;
    localparam logic [1:0] REG_MAX_ADDR   = 2'd2;

    localparam logic [7:0] START_BYTE_RST = 8'd1;
    localparam logic [7:0] MIN_ADDR_RST   = 8'd1;
    localparam logic [7:0] MAX_ADDR_RST   = 8'd247;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_LEN_MISM   = 3'd3;
    localparam logic [2:0] ST_CRC_MISM   = 3'd4;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
        logic [2:0] status;
        logic [7:0] address;
        logic [7:0] command;
        logic [7:0] len_field;
    } t_out;

    typedef struct packed {
        logic [7:0] start_byte_value;
        logic [7:0] min_address;
        logic [7:0] max_address;
    } t_cfg;

    // crc-16/modbus update over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crc16fd_core.sv
`default_nettype none

module crc16fd_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  crc16fd_pkg::t_in  i_item,
    input  crc16fd_pkg::t_cfg i_cfg,
    output logic              o_valid,
    output crc16fd_pkg::t_out o_res
);
    import crc16fd_pkg::*;

    logic [8:0]  r_pos,   n_pos;
    logic [15:0] r_crc,   n_crc;
    logic        r_start, n_start;
    logic [7:0]  r_addr,  n_addr;
    logic [7:0]  r_cmd,   n_cmd;
    logic [7:0]  r_len,   n_len;
    logic [15:0] r_rcrc,  n_rcrc;

    // state after this byte, before the end-of-frame clear
    logic [15:0] w_crc;
    logic        w_start;
    logic [7:0]  w_addr, w_cmd, w_len;
    logic [15:0] w_rcrc;
    logic        w_pay;
    logic [9:0]  w_pos10, w_crc_lo, w_flen, w_expect;
    logic [2:0]  w_status;

    always_comb begin
        w_pos10  = {1'b0, r_pos};
        w_crc_lo = 10'd4 + {2'b00, r_len};
        w_flen   = w_pos10 + 10'd1;

        w_crc   = r_crc;
        w_start = r_start;
        w_addr  = r_addr;
        w_cmd   = r_cmd;
        w_len   = r_len;
        w_rcrc  = r_rcrc;
        w_pay   = 1'b0;

        priority if (r_pos == 9'd0) begin
            w_start = (i_item.rx_byte == i_cfg.start_byte_value);
        end else if (r_pos <= 9'd3) begin
            w_crc = crc_byte(r_crc, i_item.rx_byte);
            priority if (r_pos == 9'd1) begin
                w_addr = i_item.rx_byte;
            end else if (r_pos == 9'd2) begin
                w_cmd = i_item.rx_byte;
            end else begin
                w_len = i_item.rx_byte;
            end
        end else if (w_pos10 < w_crc_lo) begin
            w_crc = crc_byte(r_crc, i_item.rx_byte);
            w_pay = 1'b1;
        end else if (w_pos10 == w_crc_lo) begin
            w_rcrc[7:0] = i_item.rx_byte;
        end else if (w_pos10 == w_crc_lo + 10'd1) begin
            w_rcrc[15:8] = i_item.rx_byte;
        end

        w_expect = FRAME_OVERHEAD + {2'b00, w_len};

        priority if (w_flen < FRAME_OVERHEAD) begin
            w_status = ST_TOO_SHORT;
        end else if (!w_start) begin
            w_status = ST_BAD_START;
        end else if (w_flen != w_expect) begin
            w_status = ST_LEN_MISM;
        end else if (w_crc != w_rcrc) begin
            w_status = ST_CRC_MISM;
        end else if (w_addr < i_cfg.min_address || w_addr > i_cfg.max_address) begin
            w_status = ST_BAD_ADDR;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_start = r_start;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_rcrc  = r_rcrc;
        o_valid = 1'b0;
        o_res   = '0;

        if (i_valid) begin
            if (i_item.frame_end) begin
                o_valid       = 1'b1;
                o_res.kind    = KIND_VERDICT;
                o_res.status  = w_status;
                if (w_status == ST_OK) begin
                    o_res.address   = w_addr;
                    o_res.command   = w_cmd;
                    o_res.len_field = w_len;
                end
                n_pos   = '0;
                n_crc   = CRC_INIT;
                n_start = 1'b0;
                n_addr  = '0;
                n_cmd   = '0;
                n_len   = '0;
                n_rcrc  = '0;
            end else begin
                n_pos   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 9'd1;
                n_crc   = w_crc;
                n_start = w_start;
                n_addr  = w_addr;
                n_cmd   = w_cmd;
                n_len   = w_len;
                n_rcrc  = w_rcrc;
                if (w_pay) begin
                    o_valid             = 1'b1;
                    o_res.kind          = KIND_PAYLOAD;
                    o_res.data_byte     = i_item.rx_byte;
                    o_res.payload_index = r_pos[7:0] - 8'd4;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_start <= 1'b0;
            r_addr  <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_rcrc  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_start <= n_start;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_rcrc  <= n_rcrc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc16_frame_decoder.sv
// channel  direction  handshake                      payload
// in       request    i_in_valid / o_in_stall        i_in_data  (rx_byte, frame_end)
// out      result     o_out_valid / i_out_stall      o_out_data (kind .. len_field)
// cfg      write      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while o_in_stall is low; a result shows once its byte has passed
// the input register, then frame logic and crc into the result queue
// the result queue of QUEUE_DEPTH entries sets how far the out side may stall
// o_in_stall rises once input register and queue together hold QUEUE_DEPTH items
// synchronous active-low reset clears frame state, queue and config to defaults
`default_nettype none

module crc16_frame_decoder #(
    parameter int unsigned QUEUE_DEPTH = crc16fd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  crc16fd_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output crc16fd_pkg::t_out o_out_data,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [1:0]         i_cfg_index,
    input  wire [7:0]         i_cfg_data
);
    import crc16fd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg;
    logic             r_in_valid;
    t_in              r_in;
    t_out             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W:0]   w_fill;

    logic w_in_acc, w_push, w_pop;
    t_out w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte_value <= START_BYTE_RST;
            r_cfg.min_address      <= MIN_ADDR_RST;
            r_cfg.max_address      <= MAX_ADDR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START_BYTE: r_cfg.start_byte_value <= i_cfg_data;
                REG_MIN_ADDR:   r_cfg.min_address      <= i_cfg_data;
                REG_MAX_ADDR:   r_cfg.max_address      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // keep room in the queue for every byte already taken
    assign w_fill     = (CNT_W+1)'(r_cnt) + (CNT_W+1)'(r_in_valid);
    assign o_in_stall = (w_fill >= (CNT_W+1)'(QUEUE_DEPTH));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
    end

    crc16fd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_valid (w_push),
        .o_res   (w_res)
    );

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc16fd_checker.sv
`default_nettype none
`include "crc16_frame_decoder_macros.svh"

module crc16fd_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input crc16fd_pkg::t_out o_out_data
);
    import crc16fd_pkg::*;

    logic w_verdict, w_payload, w_hdr_zero, w_held;
    logic w_status_ok, w_pay_ok, w_verd_ok;

    assign w_verdict  = o_out_valid && (o_out_data.kind == KIND_VERDICT);
    assign w_payload  = o_out_valid && (o_out_data.kind == KIND_PAYLOAD);
    assign w_held     = o_out_valid && i_out_stall;
    assign w_hdr_zero = (o_out_data.address == 8'd0) && (o_out_data.command == 8'd0)
                        && (o_out_data.len_field == 8'd0);

    assign w_status_ok = (o_out_data.status <= ST_BAD_ADDR);
    assign w_pay_ok    = (o_out_data.status == ST_OK) && w_hdr_zero;
    assign w_verd_ok   = (o_out_data.data_byte == 8'd0) && (o_out_data.payload_index == 8'd0)
                         && ((o_out_data.status == ST_OK) || w_hdr_zero);

    `CRC16FD_ASSERT_NOW(a_status_range, i_clk, i_rst_n, w_verdict, w_status_ok, "bad status")
    `CRC16FD_ASSERT_NOW(a_payload_clean, i_clk, i_rst_n, w_payload, w_pay_ok, "stray payload")
    `CRC16FD_ASSERT_NOW(a_verdict_clean, i_clk, i_rst_n, w_verdict, w_verd_ok, "stray verdict")
    `CRC16FD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held,
                         o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind crc16_frame_decoder crc16fd_checker u_checker (.*);

`default_nettype wire

FILE: sim/tb_crc16_frame_decoder.sv
`timescale 1ns / 100ps

module tb_crc16_frame_decoder;

    import crc16fd_pkg::*;

    localparam int ITEMS_TOTAL  = 1950;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;

    // index beyond the register map, writes there must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_byte_src;

    typedef struct {
        logic [7:0] rx;
        logic       last;
        t_byte_src  src;
        bit         use_lit;
        t_out       lit;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    crc16_frame_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // decoder copy: frame state and registers
    logic [8:0]  fr_pos;
    logic [15:0] fr_crc;
    logic        fr_start_ok;
    logic [7:0]  fr_addr;
    logic [7:0]  fr_cmd;
    logic [7:0]  fr_len;
    logic [15:0] fr_rx_crc;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_min;
    logic [7:0]  cfg_max;

    t_out        pending_results[$];
    logic [7:0]  frame_buf[$];
    t_dir_row    dir_rows[$];
    t_out        want;

    int err_count     = 0;
    int items_sent    = 0;
    int in_idle_pct   = 38;
    int out_stall_pct = 54;
    int quiet_cycles  = 0;

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void clear_frame();
        fr_pos      = '0;
        fr_crc      = CRC_INIT;
        fr_start_ok = 1'b0;
        fr_addr     = '0;
        fr_cmd      = '0;
        fr_len      = '0;
        fr_rx_crc   = '0;
    endfunction

    function automatic void decode_byte(input t_in it, output bit has_res, output t_out res);
        int         pos;
        int         plen;
        int         flen;
        bit         is_pl;
        logic [2:0] st;
        pos     = int'(fr_pos);
        plen    = int'(fr_len);
        is_pl   = 1'b0;
        has_res = 1'b0;
        res     = '0;
        if (pos == 0) begin
            fr_start_ok = (it.rx_byte == cfg_start);
        end else if (pos <= 3) begin
            fr_crc = crc16_update(fr_crc, it.rx_byte);
            if (pos == 1) begin
                fr_addr = it.rx_byte;
            end else if (pos == 2) begin
                fr_cmd = it.rx_byte;
            end else begin
                fr_len = it.rx_byte;
            end
        end else if (pos < 4 + plen) begin
            fr_crc = crc16_update(fr_crc, it.rx_byte);
            is_pl  = 1'b1;
        end else if (pos == 4 + plen) begin
            fr_rx_crc[7:0] = it.rx_byte;
        end else if (pos == 5 + plen) begin
            fr_rx_crc[15:8] = it.rx_byte;
        end

        if (it.frame_end) begin
            flen = pos + 1;
            if (flen < int'(FRAME_OVERHEAD)) begin
                st = ST_TOO_SHORT;
            end else if (!fr_start_ok) begin
                st = ST_BAD_START;
            end else if (flen != int'(FRAME_OVERHEAD) + int'(fr_len)) begin
                st = ST_LEN_MISM;
            end else if (fr_crc != fr_rx_crc) begin
                st = ST_CRC_MISM;
            end else if (fr_addr < cfg_min || fr_addr > cfg_max) begin
                st = ST_BAD_ADDR;
            end else begin
                st = ST_OK;
            end
            res.kind   = KIND_VERDICT;
            res.status = st;
            if (st == ST_OK) begin
                res.address   = fr_addr;
                res.command   = fr_cmd;
                res.len_field = fr_len;
            end
            has_res = 1'b1;
            clear_frame();
        end else begin
            fr_pos = (pos < int'(POS_MAX)) ? 9'(pos + 1) : POS_MAX;
            if (is_pl) begin
                res.kind          = KIND_PAYLOAD;
                res.data_byte     = it.rx_byte;
                res.payload_index = 8'(pos - 4);
                has_res           = 1'b1;
            end
        end
    endfunction

    function automatic t_out verdict_res(input logic [2:0] st, input logic [7:0] a,
                                         input logic [7:0] c, input logic [7:0] l);
        t_out r;
        r           = '0;
        r.kind      = KIND_VERDICT;
        r.status    = st;
        r.address   = a;
        r.command   = c;
        r.len_field = l;
        return r;
    endfunction

    function automatic t_out payload_res(input logic [7:0] d, input logic [7:0] idx);
        t_out r;
        r               = '0;
        r.kind          = KIND_PAYLOAD;
        r.data_byte     = d;
        r.payload_index = idx;
        return r;
    endfunction

    task automatic add_row(input logic [7:0] rx, input logic last, input t_byte_src src,
                           input bit use_lit, input t_out lit);
        t_dir_row r;
        r.rx      = rx;
        r.last    = last;
        r.src     = src;
        r.use_lit = use_lit;
        r.lit     = lit;
        dir_rows.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // one request on the input side, predicted once the decoder takes it
    task automatic send_byte(input t_in item, input bit use_lit, input t_out lit);
        bit   has_res;
        t_out res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        decode_byte(item, has_res, res);
        if (use_lit) begin
            pending_results.push_back(lit);
        end else if (has_res) begin
            pending_results.push_back(res);
        end
        items_sent++;
        if (items_sent < ITEMS_TOTAL / 3) begin
            in_idle_pct   = 38;
            out_stall_pct = 54;
        end else if (items_sent < 2 * ITEMS_TOTAL / 3) begin
            in_idle_pct   = 54;
            out_stall_pct = 38;
        end else begin
            in_idle_pct   = 0;
            out_stall_pct = 0;
        end
    endtask

    task automatic send_frame();
        t_in it;
        for (int i = 0; i < frame_buf.size(); i++) begin
            it.rx_byte   = frame_buf[i];
            it.frame_end = (i == frame_buf.size() - 1);
            send_byte(it, 1'b0, '0);
        end
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_START_BYTE: cfg_start = val;
            REG_MIN_ADDR:   cfg_min   = val;
            REG_MAX_ADDR:   cfg_max   = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] mn, input logic [7:0] mx);
        drain_pipeline();
        write_reg(REG_START_BYTE, s);
        write_reg(REG_MIN_ADDR, mn);
        write_reg(REG_MAX_ADDR, mx);
        write_reg(REG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic make_frame(input logic [7:0] st, input logic [7:0] addr,
                              input logic [7:0] cmd, input int plen);
        logic [15:0] c;
        logic [7:0]  b;
        frame_buf.delete();
        frame_buf.push_back(st);
        frame_buf.push_back(addr);
        frame_buf.push_back(cmd);
        frame_buf.push_back(8'(plen));
        c = crc16_update(CRC_INIT, addr);
        c = crc16_update(c, cmd);
        c = crc16_update(c, 8'(plen));
        repeat (plen) begin
            b = 8'($urandom);
            c = crc16_update(c, b);
            frame_buf.push_back(b);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    // mostly well formed frames, the rest corrupted, cut short, padded or noise
    task automatic gen_random_frame();
        int         r;
        int         sel;
        int         plen;
        int         cut;
        logic [7:0] addr;
        r   = $urandom_range(99);
        sel = $urandom_range(99);
        if (sel < 85) begin
            plen = $urandom_range(6);
        end else if (sel < 99) begin
            plen = $urandom_range(30, 7);
        end else begin
            plen = $urandom_range(255, 31);
        end
        sel = $urandom_range(9);
        case (sel)
            0: addr = cfg_min;
            1: addr = cfg_max;
            2: addr = cfg_min - 8'd1;
            3: addr = cfg_max + 8'd1;
            4: addr = 8'($urandom);
            default: addr = 8'($urandom_range(cfg_max, cfg_min));
        endcase
        if (r < 93) begin
            make_frame(cfg_start, addr, 8'($urandom), plen);
        end
        if (r >= 55 && r < 65) begin
            cut = frame_buf.size() - 1 - $urandom_range(1);
            frame_buf[cut] = frame_buf[cut] ^ (8'h01 << $urandom_range(7));
        end else if (r >= 65 && r < 72) begin
            frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(255, 1));
        end else if (r >= 72 && r < 80) begin
            cut = $urandom_range(frame_buf.size() - 1, 1);
            while (frame_buf.size() > cut) begin
                frame_buf.pop_back();
            end
        end else if (r >= 80 && r < 93) begin
            repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom));
        end else if (r >= 93) begin
            frame_buf.delete();
            repeat ($urandom_range(10, 1)) frame_buf.push_back(8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_out_data.kind));
                check_field("data_byte", want.data_byte, o_out_data.data_byte);
                check_field("payload_index", want.payload_index, o_out_data.payload_index);
                check_field("status", 8'(want.status), 8'(o_out_data.status));
                check_field("address", want.address, o_out_data.address);
                check_field("command", want.command, o_out_data.command);
                check_field("len_field", want.len_field, o_out_data.len_field);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_in it;
        int  phase_end;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_START_BYTE;
        i_cfg_data  = '0;
        cfg_start   = START_BYTE_RST;
        cfg_min     = MIN_ADDR_RST;
        cfg_max     = MAX_ADDR_RST;
        clear_frame();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone byte with frame end
        add_row(8'h01, 1'b1, SRC_LIT, 1'b1, verdict_res(ST_TOO_SHORT, 8'h00, 8'h00, 8'h00));
        // good frame at the top address, payload extremes
        add_row(8'h01, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'hF7, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'hFF, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h02, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b1, payload_res(8'h00, 8'h00));
        add_row(8'hFF, 1'b0, SRC_LIT, 1'b1, payload_res(8'hFF, 8'h01));
        add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b0, '0);
        add_row(8'h00, 1'b1, SRC_CRC_HI, 1'b1, verdict_res(ST_OK, 8'hF7, 8'hFF, 8'h02));
        // wrong start byte, otherwise sound
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h01, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b0, '0);
        add_row(8'h00, 1'b1, SRC_CRC_HI, 1'b1, verdict_res(ST_BAD_START, 8'h00, 8'h00, 8'h00));
        // frame end lands on a payload byte, that byte is not forwarded
        add_row(8'h01, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h05, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h06, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h03, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'hAA, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'hBB, 1'b1, SRC_LIT, 1'b1, verdict_res(ST_LEN_MISM, 8'h00, 8'h00, 8'h00));
        // address zero below the reset minimum
        add_row(8'h01, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_LIT, 1'b0, '0);
        add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b0, '0);
        add_row(8'h00, 1'b1, SRC_CRC_HI, 1'b1, verdict_res(ST_BAD_ADDR, 8'h00, 8'h00, 8'h00));

        foreach (dir_rows[i]) begin
            case (dir_rows[i].src)
                SRC_CRC_LO: it.rx_byte = fr_crc[7:0];
                SRC_CRC_HI: it.rx_byte = fr_crc[15:8];
                default:    it.rx_byte = dir_rows[i].rx;
            endcase
            it.frame_end = dir_rows[i].last;
            send_byte(it, dir_rows[i].use_lit, dir_rows[i].lit);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_config(8'h00, 8'h00, 8'hFF);
                1: set_config(8'hFF, 8'hFF, 8'hFF);
                2: set_config(8'($urandom), 8'd200, 8'd10);
                3: set_config(8'($urandom), 8'($urandom), 8'($urandom));
                4: set_config(START_BYTE_RST, MIN_ADDR_RST, MAX_ADDR_RST);
                default: set_config(8'($urandom), 8'($urandom_range(128)),
                                    8'($urandom_range(255, 128)));
            endcase
            phase_end = items_sent + (ITEMS_TOTAL - items_sent) / (NUM_PHASES - phase);
            if (phase == 0) begin
                // longest payload the length byte allows
                make_frame(cfg_start, 8'($urandom), 8'($urandom), 255);
                send_frame();
            end else if (phase == 3) begin
                // overlong frame, position counter saturates
                frame_buf.delete();
                frame_buf.push_back(cfg_start);
                repeat ($urandom_range(540, 520)) frame_buf.push_back(8'($urandom));
                send_frame();
            end
            while (items_sent < phase_end) begin
                gen_random_frame();
                send_frame();
            end
        end

        drain_pipeline();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
